@@ rtl/i2c_register_access_master_top_defines.svh @@
// assertion macros shared by the checker of the i2c register access master
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// same-cycle implication, off while reset is applied
`define I2CRAM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cram check failed");

// next-cycle implication, also checked across reset
`define I2CRAM_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("i2cram check failed");

`endif

@@ rtl/i2cram_pkg.sv @@
// shared types and constants of the i2c register access master
package i2cram_pkg;

    localparam int DEV_ADDR_W = 7;
    localparam int HALF_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // both queues hold two items; pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd81;
    localparam logic [HALF_W-1:0]     HALF_RESET     = 16'd5;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_HALF_PERIOD    = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } t_cmd_item;

    typedef struct packed {
        logic      valid;
        t_cmd_item item;
    } t_front_out;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              nack_error;
    } t_result;

endpackage

@@ rtl/i2c_register_access_master_top.sv @@
// top level of the i2c register access master: apb registers, front queue and bus engine
// Each item is one timing tick or a request to start a single-register write or read
// on an i2c slave; every item yields one result with the SCL/SDA drive and the status.
// The block takes one item per clock while results are popped: an item is registered
// in a two-entry input queue, the bus engine takes it from there and updates its state
// for it, and the result is registered in a two-entry result queue, from whose head it
// can be popped; the engine stalls while the result queue is full.
// Registers: device_address at byte address 0 (reset 81), half_period_ticks at byte
// address 4 (reset 5, zero acts as one); write them only while the block is idle.
module i2c_register_access_master_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [i2cram_pkg::CMD_W-1:0]           i_cmd,
    input  logic [i2cram_pkg::BYTE_W-1:0]          i_reg_addr,
    input  logic [i2cram_pkg::BYTE_W-1:0]          i_write_data,
    input  logic                                   i_sda_in,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   o_scl_level,
    output logic                                   o_sda_level,
    output logic                                   o_sda_drive,
    output logic                                   o_busy_res,
    output logic                                   o_done_res,
    output logic [i2cram_pkg::BYTE_W-1:0]          o_read_data,
    output logic                                   o_nack_error,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [i2cram_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [i2cram_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [i2cram_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                   pready
);
    import i2cram_pkg::*;

    logic [DEV_ADDR_W-1:0] r_device_address;
    logic [HALF_W-1:0]     r_half_period;
    logic                  w_reg_idx;
    logic                  w_take;
    t_front_out            w_front;
    t_result               w_result;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEV_ADDR_RESET;
            r_half_period    <= HALF_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_DEVICE_ADDRESS: r_device_address <= pwdata[DEV_ADDR_W-1:0];
                REG_HALF_PERIOD:    r_half_period    <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_DEVICE_ADDRESS: prdata = APB_DATA_W'(r_device_address);
            REG_HALF_PERIOD:    prdata = APB_DATA_W'(r_half_period);
            default:            prdata = '0;
        endcase
    end

    i2cram_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_front      (w_front),
        .i_take       (w_take)
    );

    i2cram_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_front          (w_front),
        .o_take           (w_take),
        .i_device_address (r_device_address),
        .i_half_period    (r_half_period),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_result         (w_result)
    );

    assign o_scl_level  = w_result.scl_level;
    assign o_sda_level  = w_result.sda_level;
    assign o_sda_drive  = w_result.sda_drive;
    assign o_busy_res   = w_result.busy_res;
    assign o_done_res   = w_result.done_res;
    assign o_read_data  = w_result.read_data;
    assign o_nack_error = w_result.nack_error;

endmodule

@@ rtl/i2cram_front.sv @@
// front end: accepts items, classifies the command and queues them for the bus engine
module i2cram_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [i2cram_pkg::CMD_W-1:0]       i_cmd,
    input  logic [i2cram_pkg::BYTE_W-1:0]      i_reg_addr,
    input  logic [i2cram_pkg::BYTE_W-1:0]      i_write_data,
    input  logic                               i_sda_in,
    output i2cram_pkg::t_front_out             o_front,
    input  logic                               i_take
);
    import i2cram_pkg::*;

    t_cmd_item          r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    t_cmd_item          w_item;
    logic               w_push_ok;
    logic               w_pop_ok;

    always_comb begin
        w_item.reg_addr   = i_reg_addr;
        w_item.write_data = i_write_data;
        w_item.sda_in     = i_sda_in;
        unique case (i_cmd)
            CMD_TICK:  w_item.op = OP_TICK;
            CMD_WRITE: w_item.op = OP_WRITE;
            CMD_READ:  w_item.op = OP_READ;
            default:   w_item.op = OP_TICK;  // unused code behaves as a tick
        endcase
    end

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_take && o_front.valid;

    assign o_front.valid = (r_count != '0);
    assign o_front.item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/i2cram_back.sv @@
// back end: i2c bus engine; one queued item per cycle while result queue has room
module i2cram_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  i2cram_pkg::t_front_out             i_front,
    output logic                               o_take,
    input  logic [i2cram_pkg::DEV_ADDR_W-1:0]  i_device_address,
    input  logic [i2cram_pkg::HALF_W-1:0]      i_half_period,
    input  logic                               i_pop,
    output logic                               o_empty,
    output i2cram_pkg::t_result                o_result
);
    import i2cram_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_RS_LOW,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_NACK_LOW,
        PH_NACK_HIGH,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } t_phase;

    t_phase             r_phase,      n_phase;
    logic [3:0]         r_bit_count,  n_bit_count;
    logic [BYTE_W-1:0]  r_shift,      n_shift;
    logic [HALF_W-1:0]  r_tick,       n_tick;
    logic [1:0]         r_byte_step,  n_byte_step;
    logic               r_is_read,    n_is_read;
    logic [BYTE_W-1:0]  r_held_reg,   n_held_reg;
    logic [BYTE_W-1:0]  r_held_data,  n_held_data;
    logic [BYTE_W-1:0]  r_last_read,  n_last_read;
    logic               r_error,      n_error;

    t_result            r_rq [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_rwr,        n_rwr;
    logic [QPTR_W-1:0]  r_rrd,        n_rrd;
    logic [QCNT_W-1:0]  r_rcount,     n_rcount;

    t_cmd_item          w_item;
    t_result            w_result;
    logic               w_done;
    logic               w_pop_ok;
    logic [HALF_W:0]    w_tick_inc;
    logic [HALF_W-1:0]  w_half;
    logic [3:0]         w_bit_inc;
    logic [BYTE_W-1:0]  w_rx_shift;

    assign w_item     = i_front.item;
    assign o_take     = i_front.valid && (r_rcount != QCNT_W'(QUEUE_DEPTH));
    assign w_pop_ok   = i_pop && (r_rcount != '0);
    assign o_empty    = (r_rcount == '0);
    assign o_result   = r_rq[r_rrd];

    // zero half period counts as one
    assign w_half     = (i_half_period == '0) ? HALF_W'(1) : i_half_period;
    assign w_tick_inc = {1'b0, r_tick} + (HALF_W+1)'(1);
    assign w_bit_inc  = r_bit_count + 4'd1;
    assign w_rx_shift = {r_shift[BYTE_W-2:0], w_item.sda_in};

    // line levels shown for the phase in force when the item arrives
    always_comb begin
        w_result.scl_level = 1'b1;
        w_result.sda_level = 1'b1;
        w_result.sda_drive = 1'b1;
        unique case (r_phase)
            PH_START_B: w_result.sda_level = 1'b0;
            PH_TX_LOW: begin
                w_result.scl_level = 1'b0;
                w_result.sda_level = r_shift[BYTE_W-1];
            end
            PH_TX_HIGH: w_result.sda_level = r_shift[BYTE_W-1];
            PH_ACK_LOW, PH_RX_LOW: begin
                w_result.scl_level = 1'b0;
                w_result.sda_drive = 1'b0;
            end
            PH_ACK_HIGH, PH_RX_HIGH: w_result.sda_drive = 1'b0;
            PH_RS_LOW, PH_NACK_LOW: w_result.scl_level = 1'b0;
            PH_STOP_A: begin
                w_result.scl_level = 1'b0;
                w_result.sda_level = 1'b0;
            end
            PH_STOP_B: w_result.sda_level = 1'b0;
            default: ;
        endcase
        w_result.busy_res   = (n_phase != PH_IDLE);
        w_result.done_res   = w_done;
        w_result.read_data  = n_last_read;
        w_result.nack_error = n_error;
    end

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_byte_step = r_byte_step;
        n_is_read   = r_is_read;
        n_held_reg  = r_held_reg;
        n_held_data = r_held_data;
        n_last_read = r_last_read;
        n_error     = r_error;
        w_done      = 1'b0;

        if (o_take) begin
            if (w_item.op == OP_WRITE || w_item.op == OP_READ) begin
                // requests while busy are dropped
                if (r_phase == PH_IDLE) begin
                    n_is_read   = (w_item.op == OP_READ);
                    n_held_reg  = w_item.reg_addr;
                    n_held_data = w_item.write_data;
                    n_error     = 1'b0;
                    n_byte_step = 2'd0;
                    n_bit_count = 4'd0;
                    n_tick      = '0;
                    n_shift     = {i_device_address, 1'b0};
                    n_phase     = PH_START_A;
                end
            end else if (r_phase != PH_IDLE) begin
                if (w_tick_inc >= {1'b0, w_half}) begin
                    n_tick = '0;
                    unique case (r_phase)
                        PH_START_A: n_phase = PH_START_B;
                        PH_START_B: begin
                            n_bit_count = 4'd0;
                            n_phase     = PH_TX_LOW;
                        end
                        PH_TX_LOW: n_phase = PH_TX_HIGH;
                        PH_TX_HIGH: begin
                            n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                            n_bit_count = w_bit_inc;
                            n_phase     = w_bit_inc[3] ? PH_ACK_LOW : PH_TX_LOW;
                        end
                        PH_ACK_LOW: n_phase = PH_ACK_HIGH;
                        PH_ACK_HIGH: begin
                            n_bit_count = 4'd0;
                            if (w_item.sda_in) begin
                                // missing ack: abort with a stop
                                n_error = 1'b1;
                                n_phase = PH_STOP_A;
                            end else if (r_byte_step == 2'd0) begin
                                n_shift     = r_held_reg;
                                n_byte_step = 2'd1;
                                n_phase     = PH_TX_LOW;
                            end else if (r_byte_step == 2'd1) begin
                                n_byte_step = 2'd2;
                                if (r_is_read) begin
                                    n_shift = {i_device_address, 1'b1};
                                    n_phase = PH_RS_LOW;
                                end else begin
                                    n_shift = r_held_data;
                                    n_phase = PH_TX_LOW;
                                end
                            end else if (r_byte_step == 2'd2 && r_is_read) begin
                                n_byte_step = 2'd3;
                                n_shift     = '0;
                                n_phase     = PH_RX_LOW;
                            end else begin
                                n_phase = PH_STOP_A;
                            end
                        end
                        PH_RS_LOW: n_phase = PH_START_A;
                        PH_RX_LOW: n_phase = PH_RX_HIGH;
                        PH_RX_HIGH: begin
                            n_shift     = w_rx_shift;
                            n_bit_count = w_bit_inc;
                            if (w_bit_inc[3]) begin
                                n_last_read = w_rx_shift;
                                n_phase     = PH_NACK_LOW;
                            end else begin
                                n_phase = PH_RX_LOW;
                            end
                        end
                        PH_NACK_LOW:  n_phase = PH_NACK_HIGH;
                        PH_NACK_HIGH: n_phase = PH_STOP_A;
                        PH_STOP_A:    n_phase = PH_STOP_B;
                        PH_STOP_B:    n_phase = PH_STOP_C;
                        PH_STOP_C: begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end else begin
                    n_tick = w_tick_inc[HALF_W-1:0];
                end
            end
        end
    end

    always_comb begin
        n_rwr    = o_take   ? r_rwr + 1'b1 : r_rwr;
        n_rrd    = w_pop_ok ? r_rrd + 1'b1 : r_rrd;
        n_rcount = r_rcount;
        case ({o_take, w_pop_ok})
            2'b10:   n_rcount = r_rcount + 1'b1;
            2'b01:   n_rcount = r_rcount - 1'b1;
            default: n_rcount = r_rcount;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rq[r_rwr] <= w_result;
        end
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_byte_step <= '0;
            r_is_read   <= 1'b0;
            r_held_reg  <= '0;
            r_held_data <= '0;
            r_last_read <= '0;
            r_error     <= 1'b0;
            r_rwr       <= '0;
            r_rrd       <= '0;
            r_rcount    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_tick      <= n_tick;
            r_byte_step <= n_byte_step;
            r_is_read   <= n_is_read;
            r_held_reg  <= n_held_reg;
            r_held_data <= n_held_data;
            r_last_read <= n_last_read;
            r_error     <= n_error;
            r_rwr       <= n_rwr;
            r_rrd       <= n_rrd;
            r_rcount    <= n_rcount;
        end
    end

endmodule

@@ rtl/i2cram_checker.sv @@
// port-level checks of the i2c register access master and their bind
`include "i2c_register_access_master_top_defines.svh"

module i2cram_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic o_scl_level,
    input logic o_sda_level,
    input logic o_sda_drive,
    input logic o_busy_res,
    input logic o_done_res
);

    // both queues come out of reset empty
    `I2CRAM_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, empty && !full)

    // the item that ends a transaction leaves the block idle
    `I2CRAM_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, !empty && o_done_res, !o_busy_res)

    // a released sda line always reads as a high level
    `I2CRAM_ASSERT_IMPL(a_release_high, i_clk, i_rst_n, !empty && !o_sda_drive, o_sda_level)

    // when an item leaves the bus idle, both lines are high and driven
    `I2CRAM_ASSERT_IMPL(a_idle_lines, i_clk, i_rst_n, !empty && !o_busy_res,
        o_scl_level && o_sda_level && o_sda_drive)

endmodule

bind i2c_register_access_master_top i2cram_checker u_checker (.*);
